// ===== hdl/ogci_pkg.sv =====
// Shared constants and types for the occupancy grid cross inflation block.
// No dependencies; imported by the top level and the column history store.

package ogci_pkg;

    localparam int CFG_W      = 11;
    localparam int COST_W     = 16;
    localparam int OCC_W      = 8;
    localparam int CELL_W     = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int OUT_DATA_W = 40;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [COST_W-1:0] RST_OBST_COST    = 16'd1000;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_OBSTACLE_COST = 2'd2
    } t_reg;

    typedef struct packed {
        logic en;
        logic hit;
    } t_hist_ctl;

endpackage

// ===== hdl/ogci_hist.sv =====
// Column history store: one word of recent obstacle bits per grid column.
// Sweeps itself to zero after reset; uses ogci_pkg for the read control struct.

module ogci_hist
    import ogci_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int DW    = 30
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    output logic                     o_busy,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    output logic [DW-1:0]            o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_q;
    logic [DW-1:0] r_fwd_data;
    t_hist_ctl     r_fwd;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    t_hist_ctl     n_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        n_fwd.en  = i_rd_en;
        n_fwd.hit = i_wr_en && (i_wr_addr == i_rd_addr);
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fwd.en) begin
            r_fwd      <= n_fwd;
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_busy    = r_clr_busy;
    assign o_rd_data = r_fwd.hit ? r_fwd_data : r_rd_q;

endmodule

// ===== hdl/occupancy_grid_cross_inflation_top.sv =====
// Occupancy grid cross inflation: top level with APB registers and the single-pass datapath.
// Depends on ogci_pkg and ogci_hist.

// Takes one grid cell per clock in raster order and returns one result beat per clock once the
// window has filled, while the output is not stalled: each result cell is obstacle_cost when a
// non-zero cell lies within -(RADIUS-1)..+RADIUS of it along its row or its column, else 0. The
// first result of a frame appears after RADIUS rows plus RADIUS cells have gone in; feed drain
// beats after the last cell to flush the final rows. Each beat passes through the stage register,
// where the column history word read from the store meets the row and column windows, and then
// sits in the output register. After reset the column history store is swept to zero with
// o_s_tready low.

module occupancy_grid_cross_inflation_top
    import ogci_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [OCC_W-1:0]      i_s_tdata,  // [7:0] occupancy
    input  logic                  i_s_tuser,  // [0] drain
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // [15:0] cost, [25:16] cell_x, [35:26] cell_y
    output logic                  o_m_tlast,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int SPAN = 2 * RADIUS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int RW   = CFG_W;
    localparam int NW   = RW + WW + 1;

    // configuration
    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [COST_W-1:0] r_obst_cost;
    logic              cfg_wr;
    t_reg              cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign cfg_idx  = t_reg'(i_paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_obst_cost    <= RST_OBST_COST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:   r_frame_width  <= i_pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT:  r_frame_height <= i_pwdata[CFG_W-1:0];
                REG_OBSTACLE_COST: r_obst_cost    <= i_pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:   o_prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT:  o_prdata = APB_DATA_W'(r_frame_height);
            REG_OBSTACLE_COST: o_prdata = APB_DATA_W'(r_obst_cost);
            default:           o_prdata = '0;
        endcase
    end

    // clamped frame size and derived counts
    logic [WW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [NW-1:0]    r_total;
    logic [NW-1:0]    r_lag;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (EW'(r_frame_width) > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (r_frame_height > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_lag   <= '0;
        end else begin
            r_total <= NW'(w_eff) * NW'(h_eff);
            r_lag   <= NW'(w_eff) * NW'(RADIUS) + NW'(RADIUS);
        end
    end

    // stage and state registers
    logic                  r_valid;
    logic [OCC_W-1:0]      r_occ;
    logic                  r_drain;
    logic [CW-1:0]         r_in_col;
    logic [RW-1:0]         r_in_row;
    logic [CW-1:0]         r_out_col;
    logic [CELL_W-1:0]     r_out_row;
    logic [SPAN-1:0]       r_row_win;
    logic [RADIUS:0]       r_vdel;
    logic                  r_out_valid;
    logic [COST_W-1:0]     r_out_cost;
    logic [CELL_W-1:0]     r_out_x;
    logic [CELL_W-1:0]     r_out_y;
    logic                  r_out_last;

    logic                  hist_busy;
    logic [SPAN-1:0]       hist_q;
    logic                  s_acc;
    logic                  stage_go;
    logic                  upd;
    logic [NW-1:0]         n_pos;
    logic                  in_frame;
    logic                  ignore;
    logic                  cell_bit;
    logic [SPAN-1:0]       col_word;
    logic [SPAN-1:0]       vmask;
    logic [SPAN-1:0]       hmask;
    logic                  vbit;
    logic                  hbit;
    logic                  has_res;
    logic                  res_last;
    logic [CW:0]           col_inc;
    logic [CW:0]           ocol_inc;
    logic [CW-1:0]         n_in_col;
    logic [RW-1:0]         n_in_row;
    logic [CW-1:0]         n_out_col;
    logic [CELL_W-1:0]     n_out_row;
    logic [SPAN-1:0]       n_row_win;
    logic [RADIUS:0]       n_vdel;
    logic [CW-1:0]         rd_addr;

    assign stage_go   = r_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !hist_busy && (!r_valid || stage_go);
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_pos    = NW'(r_in_row) * NW'(w_eff) + NW'(r_in_col);
        in_frame = n_pos < r_total;
        ignore   = in_frame && r_drain;
        upd      = stage_go && !ignore;
        cell_bit = in_frame && (r_occ != '0);
        col_word = {hist_q[SPAN-2:0], cell_bit};

        for (int j = 0; j < SPAN; j++) begin
            vmask[j] = (int'(r_in_row) >= j) && (int'(r_in_row) < int'(h_eff) + j);
            hmask[j] = ((j >= RADIUS) || (int'(r_out_col) + RADIUS - j < int'(w_eff)))
                    && ((j <= RADIUS) || (j - RADIUS <= int'(r_out_col)));
        end

        vbit      = |(col_word & vmask);
        n_row_win = {r_row_win[SPAN-2:0], col_word[RADIUS]};
        n_vdel    = {r_vdel[RADIUS-1:0], vbit};
        hbit      = |(n_row_win & hmask);
        has_res   = n_pos >= r_lag;
        res_last  = (WW'(r_out_col) >= w_eff - WW'(1))
                 && (CFG_W'(r_out_row) >= h_eff - CFG_W'(1));

        col_inc  = {1'b0, r_in_col} + (CW+1)'(1);
        ocol_inc = {1'b0, r_out_col} + (CW+1)'(1);

        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (col_inc >= (CW+1)'(w_eff)) begin
            n_in_col = '0;
            n_in_row = r_in_row + RW'(1);
        end else begin
            n_in_col = col_inc[CW-1:0];
        end
        if (has_res) begin
            if (res_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (ocol_inc >= (CW+1)'(w_eff)) begin
                n_out_col = '0;
                n_out_row = r_out_row + CELL_W'(1);
            end else begin
                n_out_col = ocol_inc[CW-1:0];
            end
        end

        rd_addr = upd ? n_in_col : r_in_col;
    end

    ogci_hist #(
        .DEPTH (MAX_WIDTH),
        .DW    (SPAN)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (hist_busy),
        .i_rd_en   (s_acc),
        .i_rd_addr (rd_addr),
        .i_wr_en   (upd),
        .i_wr_addr (r_in_col),
        .i_wr_data (col_word),
        .o_rd_data (hist_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_acc) begin
            r_valid <= 1'b1;
        end else if (stage_go) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_occ   <= i_s_tdata;
            r_drain <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_row_win <= '0;
            r_vdel    <= '0;
        end else if (upd) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_row_win <= n_row_win;
            r_vdel    <= n_vdel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd && has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd && has_res) begin
            r_out_cost <= (hbit || n_vdel[RADIUS]) ? r_obst_cost : '0;
            r_out_x    <= CELL_W'(r_out_col);
            r_out_y    <= r_out_row;
            r_out_last <= res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_y, r_out_x, r_out_cost});
    assign o_m_tlast  = r_out_last;

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_busy |-> !o_s_tready)
        else $error("beat accepted during history clear");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd && has_res && res_last) |=>
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("position counters not restarted after last beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(upd && has_res))
        else $error("pending result overwritten");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for occupancy_grid_cross_inflation_top: streams grid frames through the
// block and compares every result beat against a cycle-free prediction of the cross dilation.
// Depends on ogci_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import ogci_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int RADIUS      = 15;
    localparam int SPAN        = 2 * RADIUS;
    localparam int CLK_PERIOD  = 10;
    localparam int SETTLE_CYC  = 8;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [19:0][7:0] EDGE_CELLS = {
        8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
        8'h00, 8'h00, 8'h7F, 8'h00, 8'h00,
        8'h01, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              last;
    } cost_cell_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    class grid_inflation_checker;
        bit [SPAN-1:0]   col_hist [MAX_W];
        bit [SPAN-1:0]   row_win;
        bit [RADIUS:0]   vert_delay;
        int unsigned     in_x, in_y, out_x, out_y;
        bit [CFG_W-1:0]  width_reg, height_reg;
        bit [COST_W-1:0] cost_reg;
        cost_cell_t      pending_costs[$];
        int              frames_closed;
        int              errors;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            cost_reg   = RST_OBST_COST;
        endfunction

        function int unsigned clamp_size(bit [CFG_W-1:0] v, int unsigned top);
            if (v == 0)
                return 1;
            return (v > top) ? top : v;
        endfunction

        function bit [SPAN-1:0] span_mask(int unsigned lo, int unsigned hi);
            bit [SPAN-1:0] m;
            m = '0;
            for (int unsigned j = lo; j <= hi; j++)
                m[j] = 1'b1;
            return m;
        endfunction

        function void set_reg(t_reg idx, logic [APB_DATA_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:   width_reg  = val[CFG_W-1:0];
                REG_FRAME_HEIGHT:  height_reg = val[CFG_W-1:0];
                REG_OBSTACLE_COST: cost_reg   = val[COST_W-1:0];
                default: ;
            endcase
        endfunction

        function bit needs_cells();
            longint w, h;
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_HEIGHT);
            return (longint'(in_y) * w + in_x) < w * h;
        endfunction

        function int pending();
            return pending_costs.size();
        endfunction

        function void take_cell(logic [OCC_W-1:0] occ, logic drain);
            int unsigned w, h, ix, iy, lo, hi, room;
            longint      n;
            bit [SPAN-1:0] col;
            bit          hit, vhit, hbit, is_last;
            cost_cell_t  c;
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_HEIGHT);
            n = longint'(in_y) * w + in_x;
            if (n < longint'(w) * h) begin
                if (drain)
                    return;
                hit = (occ != 0);
            end else begin
                hit = 1'b0;
            end

            ix = in_x % MAX_W;
            iy = in_y;
            col = {col_hist[ix][SPAN-2:0], hit};
            col_hist[ix] = col;
            lo = (iy >= h - 1) ? iy - (h - 1) : 0;
            hi = (iy < SPAN - 1) ? iy : SPAN - 1;
            vhit = |(col & span_mask(lo, hi));
            row_win = {row_win[SPAN-2:0], col[RADIUS]};
            vert_delay = {vert_delay[RADIUS-1:0], vhit};

            in_x++;
            if (in_x >= w) begin
                in_x = 0;
                in_y++;
            end
            if (n < longint'(RADIUS) * w + RADIUS)
                return;

            room = (out_x <= w - 1) ? w - 1 - out_x : 0;
            lo = (room >= RADIUS) ? 0 : RADIUS - room;
            hi = (out_x < RADIUS - 1) ? RADIUS + out_x : SPAN - 1;
            hbit = |(row_win & span_mask(lo, hi));
            is_last = (out_x >= w - 1) && (out_y >= h - 1);
            c.cost   = (hbit || vert_delay[RADIUS]) ? cost_reg : '0;
            c.cell_x = out_x[CELL_W-1:0];
            c.cell_y = out_y[CELL_W-1:0];
            c.last   = is_last;
            pending_costs.push_back(c);

            if (is_last) begin
                in_x = 0;
                in_y = 0;
                out_x = 0;
                out_y = 0;
                frames_closed++;
            end else begin
                out_x++;
                if (out_x >= w) begin
                    out_x = 0;
                    out_y++;
                end
            end
        endfunction

        function void check_cost(logic [COST_W-1:0] cost, logic [CELL_W-1:0] x,
                                 logic [CELL_W-1:0] y, logic last);
            cost_cell_t e;
            if (pending_costs.size() == 0) begin
                $error("unexpected result beat: cost %0d at (%0d,%0d)", cost, x, y);
                errors++;
                return;
            end
            e = pending_costs.pop_front();
            if (cost !== e.cost) begin
                $error("cost mismatch: expected %0d, got %0d", e.cost, cost);
                errors++;
            end
            if (x !== e.cell_x) begin
                $error("cell_x mismatch: expected %0d, got %0d", e.cell_x, x);
                errors++;
            end
            if (y !== e.cell_y) begin
                $error("cell_y mismatch: expected %0d, got %0d", e.cell_y, y);
                errors++;
            end
            if (last !== e.last) begin
                $error("last mismatch: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OCC_W-1:0]      i_s_tdata  = '0;  // [7:0] occupancy
    logic                  i_s_tuser  = 1'b0;  // [0] drain
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;  // [15:0] cost, [25:16] cell_x, [35:26] cell_y
    logic                  o_m_tlast;
    logic                  i_psel     = 1'b0;
    logic                  i_penable  = 1'b0;
    logic                  i_pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] i_paddr    = '0;
    logic [APB_DATA_W-1:0] i_pwdata   = '0;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    grid_inflation_checker sb;
    int          burst_left = 0;
    int          cells_sent = 0;
    int unsigned cycle_count = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_hold_left = 0;
    bit          rx_hold_done = 1'b0;
    int          rx_tick = 0;
    int          results_seen = 0;

    occupancy_grid_cross_inflation_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check each beat, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_cost(o_m_tdata[15:0], o_m_tdata[25:16], o_m_tdata[35:26], o_m_tlast);
                results_seen++;
            end
            rx_tick++;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_tready <= 1'b0;
            end else if (!rx_hold_done && results_seen >= 500) begin
                rx_hold_done = 1'b1;
                rx_hold_left = 600;
                i_m_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    RX_OPEN:    i_m_tready <= 1'b1;
                    RX_RANDOM:  i_m_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: i_m_tready <= (rx_tick % 5) < 3;
                    default:    i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic apb_write(input t_reg idx, input logic [APB_DATA_W-1:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_beat(input logic [OCC_W-1:0] occ, input logic drain);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= occ;
        i_s_tuser  <= drain;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.take_cell(occ, drain);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // hold the input until every predicted result has left the block
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_grid(input int w, input int h, input int cost);
        settle();
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_OBSTACLE_COST, cost);
    endtask

    function automatic logic [OCC_W-1:0] grid_value(input int pct);
        return ($urandom_range(0, 99) < pct) ? OCC_W'($urandom_range(1, 255)) : '0;
    endfunction

    function automatic int pick_density();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 2;
            2: return 5;
            3: return 15;
            4: return 50;
            default: return 100;
        endcase
    endfunction

    function automatic int pick_size();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    endfunction

    task automatic fill_frame(input int pct, input int max_cells);
        int k;
        k = 0;
        while (sb.needs_cells() && k < max_cells) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(OCC_W'($urandom), 1'b1);
            send_beat(grid_value(pct), 1'b0);
            k++;
            cells_sent++;
        end
    endtask

    // after the frame's cells a plain cell only advances the pipeline, like a drain
    task automatic flush_beat();
        send_beat(OCC_W'($urandom), ($urandom_range(0, 3) != 0));
    endtask

    task automatic close_frame();
        int closed;
        closed = sb.frames_closed;
        while (sb.frames_closed == closed) begin
            if (sb.needs_cells())
                send_beat(grid_value(10), 1'b0);
            else
                flush_beat();
        end
    endtask

    task automatic run_frame(input int pct);
        fill_frame(pct, 1 << 30);
        close_frame();
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_grid(5, 4, 1234);
        for (int i = 19; i >= 0; i--) begin
            if (i == 12)
                send_beat(8'h55, 1'b1);
            send_beat(EDGE_CELLS[i], 1'b0);
        end
        close_frame();

        set_grid(1, 1, 65535);
        run_frame(100);
        set_grid(0, 0, 0);
        run_frame(100);

        // shrink the height before any result, change the cost once results flow
        set_grid(8, 6, 77);
        fill_frame(20, 10);
        settle();
        apb_write(REG_FRAME_HEIGHT, 3);
        fill_frame(20, 1000);
        repeat (116) flush_beat();
        settle();
        apb_write(REG_OBSTACLE_COST, 4321);
        close_frame();

        // narrow the row while the input column sits past the new width
        set_grid(12, 5, 9);
        fill_frame(30, 46);
        settle();
        apb_write(REG_FRAME_WIDTH, 7);
        run_frame(30);

        set_grid(1024, 2, 500);
        run_frame(1);
        set_grid(2047, 0, 65535);
        run_frame(2);
        set_grid(1, 1024, 1);
        run_frame(3);
        set_grid(0, 2047, 42);
        run_frame(1);
        set_grid(16, 16, 3000);
        run_frame(5);
        set_grid(31, 30, 17);
        run_frame(8);

        cells_sent = 0;
        while (cells_sent < 400) begin
            if ($urandom_range(0, 2) != 0) begin
                settle();
                if ($urandom_range(0, 2) != 0)
                    apb_write(REG_FRAME_WIDTH, pick_size());
                if ($urandom_range(0, 2) != 0)
                    apb_write(REG_FRAME_HEIGHT, pick_size());
                if ($urandom_range(0, 2) != 0)
                    apb_write(REG_OBSTACLE_COST, $urandom_range(0, 65535));
            end
            run_frame(pick_density());
        end

        settle();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
